[rtl/rms_pkg.sv]
// shared constants and helpers for the running median stream unit
// no dependencies
`default_nettype none

package rms_pkg;

	// number of cells folded into one first-level group of the median select tree
	localparam int GRP_SIZE = 16;

	// number of select groups needed to cover a given store depth
	function automatic int num_groups(input int cap);
		return (cap + GRP_SIZE - 1) / GRP_SIZE;
	endfunction

endpackage

`default_nettype wire

[rtl/rms_sample_if.sv]
// valid/ready channel carrying one signed sample per item
// no dependencies
`default_nettype none

interface rms_sample_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[rtl/rms_result_if.sv]
// valid/ready channel carrying one median result per item
// no dependencies
`default_nettype none

interface rms_result_if #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_W     = 9
);
	logic                        valid;
	logic                        ready;
	logic signed [SAMPLE_BITS:0] median_halves;
	logic [COUNT_W-1:0]          stored_count;
	logic                        refused;

	modport source (output valid, output median_halves, output stored_count,
		output refused, input ready);
	modport sink   (input valid, input median_halves, input stored_count,
		input refused, output ready);
endinterface

`default_nettype wire

[rtl/running_median_stream_unit.sv]
// running median: one item in, one result out for each accepted item
// one item in flight at a time: the insertion row updates, then the two-level
// select tree registers group picks; its second level feeds the result register
// the result register lets the next item in while a result waits to be taken
// reset clears the count and handshake state; cell contents stay undefined
// depends on rms_pkg, rms_sample_if, rms_result_if, rms_cell, rms_select
`default_nettype none

module running_median_stream_unit
	import rms_pkg::*;
#(
	parameter int CAPACITY    = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	rms_sample_if.sink    samples,
	rms_result_if.source  results
);
	localparam int COUNT_W = $clog2(CAPACITY + 1);
	localparam int NGRP    = num_groups(CAPACITY);

	// handshake and pipeline control
	logic                   in_acc;
	logic                   full;
	logic                   ins_en;
	logic                   v_s1_q;
	logic                   v_s2_q;
	logic                   out_load;
	logic                   out_valid_q;

	// sample count and per-item flag
	logic [COUNT_W-1:0]     count_q;
	logic                   refused_q;

	// cell row links
	logic                   gt   [CAPACITY];
	logic [SAMPLE_BITS-1:0] vals [CAPACITY];

	// middle entries and result registers
	logic [SAMPLE_BITS-1:0] mid_lo;
	logic [SAMPLE_BITS-1:0] mid_hi;
	logic [SAMPLE_BITS:0]   median_sum;
	logic [SAMPLE_BITS:0]   median_q;
	logic [COUNT_W-1:0]     stored_q;
	logic                   refused_out_q;

	// only one item is worked on at once; the output register is separate
	assign samples.ready = !v_s1_q && !v_s2_q;
	assign in_acc        = samples.valid && samples.ready;
	assign full          = count_q == COUNT_W'(CAPACITY);
	// a full store drops the sample and leaves the row untouched
	assign ins_en        = in_acc && !full;
	assign out_load      = v_s2_q && (!out_valid_q || results.ready);

	// insertion row: each cell compares against the sample in parallel and
	// takes its lower neighbor's entry when that one is shifting up
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                          prev_gt;
		logic signed [SAMPLE_BITS-1:0] prev_val;
		logic signed [SAMPLE_BITS-1:0] cell_val;

		if (i == 0) begin : g_first
			assign prev_gt  = 1'b0;
			assign prev_val = '0;
		end else begin : g_rest
			assign prev_gt  = gt[i-1];
			assign prev_val = vals[i-1];
		end

		rms_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.COUNT_W     (COUNT_W),
			.IDX         (i)
		) u_cell (
			.clk      (clk),
			.ins_en   (ins_en),
			.x        (samples.sample),
			.count    (count_q),
			.prev_gt  (prev_gt),
			.prev_val (prev_val),
			.gt       (gt[i]),
			.val      (cell_val)
		);

		assign vals[i] = cell_val;
	end

	// picks the middle pair once the row and count have settled
	rms_select #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.CAPACITY    (CAPACITY),
		.COUNT_W     (COUNT_W),
		.NGRP        (NGRP)
	) u_select (
		.clk   (clk),
		.load  (v_s1_q),
		.vals  (vals),
		.count (count_q),
		.lo    (mid_lo),
		.hi    (mid_hi)
	);

	// twice the median: for an odd count both picks are the same entry
	assign median_sum = {mid_lo[SAMPLE_BITS-1], mid_lo} + {mid_hi[SAMPLE_BITS-1], mid_hi};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ins_en) begin
				count_q <= count_q + COUNT_W'(1);
			end
			v_s1_q      <= in_acc;
			v_s2_q      <= v_s1_q || (v_s2_q && !out_load);
			out_valid_q <= out_load || (out_valid_q && !results.ready);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			refused_q <= full;
		end
		if (out_load) begin
			median_q      <= median_sum;
			stored_q      <= count_q;
			refused_out_q <= refused_q;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.median_halves = median_q;
	assign results.stored_count  = stored_q;
	assign results.refused       = refused_out_q;
endmodule

`default_nettype wire

[rtl/rms_cell.sv]
// one sorted insertion cell: holds one store entry, shifts up when a smaller sample arrives
// no dependencies
`default_nettype none

module rms_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_W     = 9,
	parameter int IDX         = 0
) (
	input  wire logic                          clk,
	input  wire logic                          ins_en,
	input  wire logic signed [SAMPLE_BITS-1:0] x,
	input  wire logic [COUNT_W-1:0]            count,
	input  wire logic                          prev_gt,
	input  wire logic signed [SAMPLE_BITS-1:0] prev_val,
	output logic                               gt,
	output logic signed [SAMPLE_BITS-1:0]      val
);
	logic signed [SAMPLE_BITS-1:0] val_q;
	logic                          occupied;
	logic                          at_end;
	logic                          take_x;

	assign occupied = COUNT_W'(IDX) < count;
	assign at_end   = COUNT_W'(IDX) == count;
	// held entries strictly above the sample move up one cell
	assign gt       = occupied && (val_q > x);
	assign take_x   = !prev_gt && (gt || at_end);
	assign val      = val_q;

	always_ff @(posedge clk) begin
		if (ins_en) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (take_x) begin
				val_q <= x;
			end
		end
	end
endmodule

`default_nettype wire

[rtl/rms_select.sv]
// two-level select tree that picks the two middle entries out of the cell row
// depends on rms_pkg
`default_nettype none

module rms_select
	import rms_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int CAPACITY    = 256,
	parameter int COUNT_W     = 9,
	parameter int NGRP        = 16
) (
	input  wire logic                   clk,
	input  wire logic                   load,
	input  wire logic [SAMPLE_BITS-1:0] vals [CAPACITY],
	input  wire logic [COUNT_W-1:0]     count,
	output logic [SAMPLE_BITS-1:0]      lo,
	output logic [SAMPLE_BITS-1:0]      hi
);
	logic [COUNT_W-1:0]     hi_idx;
	logic [COUNT_W-1:0]     lo_idx;
	logic [SAMPLE_BITS-1:0] grp_lo [NGRP];
	logic [SAMPLE_BITS-1:0] grp_hi [NGRP];
	logic [SAMPLE_BITS-1:0] lo_s1  [NGRP];
	logic [SAMPLE_BITS-1:0] hi_s1  [NGRP];

	// odd count: both picks hit the middle entry; even: the pair around the middle
	assign hi_idx = {1'b0, count[COUNT_W-1:1]};
	assign lo_idx = hi_idx - COUNT_W'(!count[0]);

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_lo[g] = '0;
			grp_hi[g] = '0;
			for (int k = 0; k < GRP_SIZE; k++) begin
				if (g * GRP_SIZE + k < CAPACITY) begin
					if (COUNT_W'(g * GRP_SIZE + k) == lo_idx) begin
						grp_lo[g] = grp_lo[g] | vals[g * GRP_SIZE + k];
					end
					if (COUNT_W'(g * GRP_SIZE + k) == hi_idx) begin
						grp_hi[g] = grp_hi[g] | vals[g * GRP_SIZE + k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lo_s1 <= grp_lo;
			hi_s1 <= grp_hi;
		end
	end

	always_comb begin
		lo = '0;
		hi = '0;
		for (int g = 0; g < NGRP; g++) begin
			lo = lo | lo_s1[g];
			hi = hi | hi_s1[g];
		end
	end
endmodule

`default_nettype wire
